@@ rtl/ctt_pkg.sv @@
// Shared types, token codes and character-class helpers for the config text tokenizer.
// No dependencies; every other file in rtl/ imports this package.
package ctt_pkg;

   localparam int unsigned TOKEN_LEN_MAX_DEF = 255;
   localparam int unsigned BUFFER_BYTES_DEF  = 65536;
   localparam int unsigned LINE_MAX_DEF      = 65535;

   localparam logic [3:0] KIND_END    = 4'd0;
   localparam logic [3:0] KIND_SERVER = 4'd1;
   localparam logic [3:0] KIND_NAME   = 4'd2;
   localparam logic [3:0] KIND_PORT   = 4'd3;
   localparam logic [3:0] KIND_LBRACE = 4'd4;
   localparam logic [3:0] KIND_RBRACE = 4'd5;
   localparam logic [3:0] KIND_NUMBER = 4'd6;
   localparam logic [3:0] KIND_IDENT  = 4'd7;
   localparam logic [3:0] KIND_ERROR  = 4'd8;

   localparam logic [1:0] KW_SERVER = 2'd0;
   localparam logic [1:0] KW_NAME   = 2'd1;
   localparam logic [1:0] KW_PORT   = 2'd2;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_P      = 8'h70;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = 2;
   localparam int unsigned RSP_CNT_W = 3;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [7:0]  token_length;
      logic [15:0] start_offset;
      logic [15:0] line_number;
      logic        run_end;
   } rsp_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_digit(c) || is_alpha(c) || (c == CH_DOT);
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] len;
      case (k)
         KW_SERVER: len = 3'd6;
         KW_NAME:   len = 3'd4;
         KW_PORT:   len = 3'd4;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
      logic [7:0] ch;
      ch = 8'h00;
      case (k)
         KW_SERVER: begin
            case (p)
               3'd0:    ch = 8'h73;
               3'd1:    ch = 8'h65;
               3'd2:    ch = 8'h72;
               3'd3:    ch = 8'h76;
               3'd4:    ch = 8'h65;
               3'd5:    ch = 8'h72;
               default: ch = 8'h00;
            endcase
         end
         KW_NAME: begin
            case (p)
               3'd0:    ch = 8'h6E;
               3'd1:    ch = 8'h61;
               3'd2:    ch = 8'h6D;
               3'd3:    ch = 8'h65;
               default: ch = 8'h00;
            endcase
         end
         KW_PORT: begin
            case (p)
               3'd0:    ch = 8'h70;
               3'd1:    ch = 8'h6F;
               3'd2:    ch = 8'h72;
               3'd3:    ch = 8'h74;
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ rtl/config_text_tokenizer_unit.sv @@
// Top level of the config text tokenizer: input byte register, scanner and result queue.
// Depends on ctt_pkg, ctt_scan and ctt_rsp_fifo.
//
//   channel | direction | fields
//   req     | in        | data_byte[7:0], last_byte
//   rsp     | out       | token_kind[3:0], token_length[7:0], start_offset[15:0],
//           |           | line_number[15:0], run_end
//
// One byte per cycle while the queue has room: each byte is held in the input register,
// scanned, and its results are written into a four-entry queue, from which its first
// result is offered. The rsp port gives one result per cycle while rsp_ready is high;
// a byte gives at most one result, the final byte up to two. The input register advances
// only while the queue has room for two, so a stalled rsp side backs up into req_ready.
// Synchronous reset returns the scanner to line 1, offset 0, between tokens.
module config_text_tokenizer_unit #(
   parameter int unsigned TOKEN_LEN_MAX = ctt_pkg::TOKEN_LEN_MAX_DEF,
   parameter int unsigned BUFFER_BYTES  = ctt_pkg::BUFFER_BYTES_DEF,
   parameter int unsigned LINE_MAX      = ctt_pkg::LINE_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [7:0]  rsp_token_length,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_line_number,
   output logic        rsp_run_end
);
   import ctt_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       adv;
   logic       room;
   logic [1:0] res_count;
   logic [1:0] push_n;
   rsp_type    res0, res1, rsp_item;

   assign adv         = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || adv;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign push_n      = adv ? res_count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   ctt_scan #(
      .TOKEN_LEN_MAX (TOKEN_LEN_MAX),
      .BUFFER_BYTES  (BUFFER_BYTES),
      .LINE_MAX      (LINE_MAX)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .data_byte (byte_ff),
      .last_byte (last_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   ctt_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push0     (res0),
      .push1     (res1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_token_kind   = rsp_item.token_kind;
   assign rsp_token_length = rsp_item.token_length;
   assign rsp_start_offset = rsp_item.start_offset;
   assign rsp_line_number  = rsp_item.line_number;
   assign rsp_run_end      = rsp_item.run_end;

   a_byte_gives_result: assert property (@(posedge clock) disable iff (reset)
      adv && last_ff |-> res_count != 2'd0)
      else $error("final byte produced no end token");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(byte_ff) && $stable(last_ff))
      else $error("input register changed while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      res_count != 2'd3)
      else $error("more than two results for one byte");
endmodule

@@ rtl/ctt_scan.sv @@
// Scanner state and per-byte token logic: one registered byte in, up to two results out.
// Depends on ctt_pkg for token codes, keyword tables and character classes.
module ctt_scan #(
   parameter int unsigned TOKEN_LEN_MAX = ctt_pkg::TOKEN_LEN_MAX_DEF,
   parameter int unsigned BUFFER_BYTES  = ctt_pkg::BUFFER_BYTES_DEF,
   parameter int unsigned LINE_MAX      = ctt_pkg::LINE_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [7:0]       data_byte,
   input  logic             last_byte,
   output ctt_pkg::rsp_type res0,
   output ctt_pkg::rsp_type res1,
   output logic [1:0]       res_count
);
   import ctt_pkg::*;

   localparam int unsigned LEN_W  = $clog2(TOKEN_LEN_MAX + 1);
   localparam int unsigned OFF_W  = $clog2(BUFFER_BYTES);
   localparam int unsigned LINE_W = $clog2(LINE_MAX + 1);
   localparam int unsigned LEN_X  = (LEN_W > 8) ? LEN_W : 8;
   localparam int unsigned OFF_X  = (OFF_W > 16) ? OFF_W : 16;
   localparam int unsigned LINE_X = (LINE_W > 16) ? LINE_W : 16;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_DIGITS = 2'd1;
   localparam logic [1:0] MODE_WORD   = 2'd2;
   localparam logic [1:0] MODE_SKIP   = 2'd3;

   logic [1:0]        mode_ff,  mode_in;
   logic [2:0]        cand_ff,  cand_in;
   logic [2:0]        pos_ff,   pos_in;
   logic [LEN_W-1:0]  len_ff,   len_in;
   logic [OFF_W-1:0]  start_ff, start_in;
   logic [OFF_W-1:0]  off_ff,   off_in;
   logic [LINE_W-1:0] line_ff,  line_in;

   logic              ws, digit, word, brace, newline;
   logic [1:0]        kw_idx;
   logic [2:0]        kw_n;
   logic [2:0]        pos_inc;
   logic              tok_v;
   logic [3:0]        tok_kind;
   logic [LEN_W-1:0]  tok_len;
   logic              tok_kw;
   logic              tok_at_off;
   logic [LINE_W-1:0] line_cnt;
   logic [LEN_X-1:0]  tok_len_x;
   logic [OFF_X-1:0]  off_x, start_x;
   logic [LINE_X-1:0] line_x, line_cnt_x;
   rsp_type           tok_r, end_r;

   assign ws      = is_ws(data_byte);
   assign digit   = is_digit(data_byte);
   assign word    = is_word(data_byte);
   assign brace   = (data_byte == CH_LBRACE) || (data_byte == CH_RBRACE);
   assign newline = (data_byte == CH_LF);
   assign kw_idx  = cand_ff[0] ? KW_SERVER : (cand_ff[1] ? KW_NAME : KW_PORT);
   assign kw_n    = kw_len(kw_idx);
   assign pos_inc = pos_ff + 3'd1;

   always_comb begin
      mode_in    = mode_ff;
      cand_in    = cand_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      start_in   = start_ff;
      line_cnt   = line_ff;
      tok_v      = 1'b0;
      tok_kind   = KIND_ERROR;
      tok_len    = len_ff;
      tok_kw     = 1'b0;
      tok_at_off = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (ws) begin
               if (newline && (line_ff < LINE_W'(LINE_MAX))) begin
                  line_cnt = line_ff + 1'b1;
               end
            end else if (brace) begin
               tok_v      = 1'b1;
               tok_kind   = (data_byte == CH_LBRACE) ? KIND_LBRACE : KIND_RBRACE;
               tok_len    = LEN_W'(1);
               tok_at_off = 1'b1;
            end else if (word) begin
               start_in = off_ff;
               len_in   = LEN_W'(1);
               mode_in  = digit ? MODE_DIGITS : MODE_WORD;
               cand_in  = (data_byte == CH_S) ? 3'b001 :
                          (data_byte == CH_N) ? 3'b010 :
                          (data_byte == CH_P) ? 3'b100 : 3'b000;
               pos_in   = (cand_in != 3'b000) ? 3'd1 : 3'd0;
               if (last_byte) begin
                  tok_v      = 1'b1;
                  tok_kind   = digit ? KIND_NUMBER : KIND_IDENT;
                  tok_len    = LEN_W'(1);
                  tok_at_off = 1'b1;
               end
            end else begin
               tok_v      = 1'b1;
               tok_kind   = KIND_ERROR;
               tok_len    = '0;
               tok_at_off = 1'b1;
               mode_in    = MODE_SKIP;
            end
         end
         MODE_DIGITS, MODE_WORD: begin
            if ((cand_ff != 3'b000) && (pos_ff < kw_n) &&
                (data_byte == kw_char(kw_idx, pos_ff))) begin
               pos_in = pos_inc;
            end else if (cand_ff != 3'b000) begin
               cand_in = 3'b000;
               pos_in  = 3'd0;
            end
            if ((cand_ff != 3'b000) && (pos_ff < kw_n) &&
                (data_byte == kw_char(kw_idx, pos_ff)) && (pos_inc == kw_n)) begin
               tok_v    = 1'b1;
               tok_kind = {2'b00, kw_idx} + 4'd1;
               tok_kw   = 1'b1;
               mode_in  = MODE_IDLE;
               cand_in  = 3'b000;
               pos_in   = 3'd0;
               len_in   = '0;
            end else if (word) begin
               if (len_ff < LEN_W'(TOKEN_LEN_MAX)) begin
                  len_in = len_ff + 1'b1;
               end
               if (!digit) begin
                  mode_in = MODE_WORD;
               end
               if (last_byte) begin
                  tok_v    = 1'b1;
                  tok_kind = (mode_in == MODE_DIGITS) ? KIND_NUMBER : KIND_IDENT;
                  tok_len  = len_in;
               end
            end else if (ws) begin
               tok_v    = 1'b1;
               tok_kind = (mode_ff == MODE_DIGITS) ? KIND_NUMBER : KIND_IDENT;
               mode_in  = MODE_IDLE;
               cand_in  = 3'b000;
               pos_in   = 3'd0;
               len_in   = '0;
               if (newline && (line_ff < LINE_W'(LINE_MAX))) begin
                  line_cnt = line_ff + 1'b1;
               end
            end else begin
               tok_v    = 1'b1;
               tok_kind = KIND_ERROR;
               mode_in  = MODE_SKIP;
               cand_in  = 3'b000;
               pos_in   = 3'd0;
               len_in   = '0;
            end
         end
         default: begin
         end
      endcase
      line_in = line_cnt;
      off_in  = (off_ff < OFF_W'(BUFFER_BYTES - 1)) ? off_ff + 1'b1 : off_ff;
      if (last_byte) begin
         mode_in  = MODE_IDLE;
         cand_in  = 3'b000;
         pos_in   = 3'd0;
         len_in   = '0;
         start_in = '0;
         off_in   = '0;
         line_in  = LINE_W'(1);
      end
   end

   assign tok_len_x  = LEN_X'(tok_len);
   assign off_x      = OFF_X'(off_ff);
   assign start_x    = OFF_X'(start_ff);
   assign line_x     = LINE_X'(line_ff);
   assign line_cnt_x = LINE_X'(line_cnt);

   always_comb begin
      tok_r.token_kind   = tok_kind;
      tok_r.token_length = tok_kw ? {5'd0, kw_n} : tok_len_x[7:0];
      tok_r.start_offset = tok_at_off ? off_x[15:0] : start_x[15:0];
      tok_r.line_number  = line_x[15:0];
      tok_r.run_end      = !last_byte;
      end_r.token_kind   = KIND_END;
      end_r.token_length = 8'd0;
      end_r.start_offset = off_x[15:0];
      end_r.line_number  = line_cnt_x[15:0];
      end_r.run_end      = 1'b1;
   end

   assign res0      = tok_v ? tok_r : end_r;
   assign res1      = end_r;
   assign res_count = {1'b0, tok_v} + {1'b0, last_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cand_ff  <= 3'b000;
         pos_ff   <= 3'd0;
         len_ff   <= '0;
         start_ff <= '0;
         off_ff   <= '0;
         line_ff  <= LINE_W'(1);
      end else if (adv) begin
         mode_ff  <= mode_in;
         cand_ff  <= cand_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         off_ff   <= off_in;
         line_ff  <= line_in;
      end
   end

   a_cand_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cand_ff))
      else $error("keyword candidates not one-hot");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      adv && last_byte |=> (mode_ff == MODE_IDLE) && (off_ff == '0) &&
                           (line_ff == LINE_W'(1)))
      else $error("buffer end did not restore scanner state");

   a_skip_on_error: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_SKIP) && (mode_in == MODE_SKIP) && !last_byte |->
         tok_v && (tok_kind == KIND_ERROR))
      else $error("skip entered without an error token");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line count reached zero");
endmodule

@@ rtl/ctt_rsp_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per rsp handshake.
// Depends on ctt_pkg for the result type and queue sizing.
module ctt_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_n,
   input  ctt_pkg::rsp_type push0,
   input  ctt_pkg::rsp_type push1,
   output logic             room,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctt_pkg::rsp_type rsp_item
);
   import ctt_pkg::*;

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff,  count_in;
   logic [RSP_PTR_W-1:0]   wr_ptr_next;
   logic                   pop;

   assign room        = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_item    = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign wr_ptr_in   = wr_ptr_ff + RSP_PTR_W'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in    = count_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_next] <= push1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> room)
      else $error("push into queue without room");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      RSP_PTR_W'(wr_ptr_ff - rd_ptr_ff) == RSP_PTR_W'(count_ff))
      else $error("queue pointers disagree with count");
endmodule
